// ----- rtl/bilinear_texture_sampler_top_defines.svh -----
// Assertion macros for the texture sampler.
`ifndef BILINEAR_TEXTURE_SAMPLER_TOP_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BTS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define BTS_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define BTS_ASSERT(label, clk, rst, prop)
`define BTS_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- rtl/bts_pkg.sv -----
package bts_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_POINT    = 2'd1,
    REQ_BILINEAR = 2'd2,
    REQ_HLINEAR  = 2'd3
  } req_t;

  localparam int REG_WIDTH_IDX  = 0;
  localparam int REG_HEIGHT_IDX = 1;
  localparam int CFG_W          = 9;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_BLEND_X,
    BK_BLEND_Y,
    BK_OUT
  } bk_state_t;

  // Per-channel truncating blend of two RGBA8 words.
  function automatic logic [31:0] blend4(input logic [31:0] a, input logic [31:0] b,
                                         input logic [15:0] w);
    logic [16:0] wa;
    logic [24:0] pa;
    logic [24:0] pb;
    logic [31:0] r;
    wa = 17'h10000 - {1'b0, w};
    r  = '0;
    for (int c = 0; c < 4; c++) begin
      pa = a[c*8 +: 8] * wa;
      pb = b[c*8 +: 8] * w;
      r[c*8 +: 8] = pa[23:16] + pb[23:16];
    end
    return r;
  endfunction

endpackage

// ----- rtl/bts_ram.sv -----
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/bts_front.sv -----
// Front end: clamps coordinates, locates sample positions and queues one
// decoded command for the back end.
module bts_front #(
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bts_pkg::req_t             req_type,
  input  logic signed [15:0]        pixel_x,
  input  logic signed [15:0]        pixel_y,
  input  logic [31:0]               sample_u,
  input  logic [31:0]               sample_v,
  input  logic [31:0]               in_color,
  input  logic [XW:0]               eff_w,
  input  logic [YW:0]               eff_h,
  output logic                      cmd_valid,
  input  logic                      cmd_ready,
  output bts_pkg::req_t             cmd_type,
  output logic [XW-1:0]             cmd_x0,
  output logic [XW-1:0]             cmd_x1,
  output logic [YW-1:0]             cmd_y0,
  output logic [YW-1:0]             cmd_y1,
  output logic [15:0]               cmd_wx,
  output logic [15:0]               cmd_wy,
  output logic [31:0]               cmd_color
);
  import bts_pkg::*;

  // Two-stage pipeline: stage A holds the product, stage B the command.
  logic              a_valid;
  req_t              a_type;
  logic [XW-1:0]     a_px;
  logic [YW-1:0]     a_py;
  logic [XW+16:0]    a_su;
  logic [YW+16:0]    a_sv;
  logic [31:0]       a_color;
  logic              a_ready;

  logic [XW-1:0]     px_c;
  logic [YW-1:0]     py_c;
  logic [XW-1:0]     wm1;
  logic [YW-1:0]     hm1;
  logic [XW+16:0]    su_pos;
  logic [YW+16:0]    sv_pos;
  logic [XW-1:0]     xi;
  logic [YW-1:0]     yi;
  logic [XW-1:0]     xi1;
  logic [YW-1:0]     yi1;

  assign wm1 = XW'(eff_w - 1'b1);
  assign hm1 = YW'(eff_h - 1'b1);

  // Clamp integer coordinates to the image.
  always_comb begin
    if (pixel_x < 0) begin
      px_c = '0;
    end else if ({1'b0, pixel_x[14:0]} > 16'(wm1)) begin
      px_c = wm1;
    end else begin
      px_c = XW'(pixel_x);
    end
    if (pixel_y < 0) begin
      py_c = '0;
    end else if ({1'b0, pixel_y[14:0]} > 16'(hm1)) begin
      py_c = hm1;
    end else begin
      py_c = YW'(pixel_y);
    end
  end

  assign a_ready  = !cmd_valid || cmd_ready;
  assign in_ready = !a_valid || a_ready;

  // Stage A: fraction times size.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_type  <= req_type;
      a_px    <= px_c;
      a_py    <= py_c;
      a_su    <= sample_u[15:0] * eff_w;
      a_sv    <= sample_v[15:0] * eff_h;
      a_color <= in_color;
    end
  end

  // Offset by half a texel and clamp to the edge.
  always_comb begin
    if (a_su < (XW+17)'(17'h8000)) begin
      su_pos = '0;
    end else begin
      su_pos = a_su - (XW+17)'(17'h8000);
    end
    if (su_pos > {1'b0, wm1, 16'h0}) begin
      su_pos = {1'b0, wm1, 16'h0};
    end
    if (a_sv < (YW+17)'(17'h8000)) begin
      sv_pos = '0;
    end else begin
      sv_pos = a_sv - (YW+17)'(17'h8000);
    end
    if (sv_pos > {1'b0, hm1, 16'h0}) begin
      sv_pos = {1'b0, hm1, 16'h0};
    end
    xi  = su_pos[XW+15:16];
    yi  = sv_pos[YW+15:16];
    xi1 = (xi == wm1) ? xi : XW'(xi + 1'b1);
    yi1 = (yi == hm1) ? yi : YW'(yi + 1'b1);
  end

  // Stage B: the command register that parts front and back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (a_ready) begin
      cmd_valid <= a_valid;
    end
    if (a_ready && a_valid) begin
      cmd_type  <= a_type;
      cmd_color <= a_color;
      unique case (a_type)
        REQ_WRITE, REQ_POINT: begin
          cmd_x0 <= a_px; cmd_x1 <= a_px; cmd_y0 <= a_py; cmd_y1 <= a_py;
          cmd_wx <= '0;   cmd_wy <= '0;
        end
        REQ_HLINEAR: begin
          cmd_x0 <= xi;   cmd_x1 <= xi1;  cmd_y0 <= a_py; cmd_y1 <= a_py;
          cmd_wx <= su_pos[15:0]; cmd_wy <= '0;
        end
        default: begin
          cmd_x0 <= xi;   cmd_x1 <= xi1;  cmd_y0 <= yi;   cmd_y1 <= yi1;
          cmd_wx <= su_pos[15:0]; cmd_wy <= sv_pos[15:0];
        end
      endcase
    end
  end
endmodule

// ----- rtl/bts_back.sv -----
// Back end: texel store, four-read fetch sequencer and channel blends.
module bts_back #(
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  bts_pkg::req_t        cmd_type,
  input  logic [XW-1:0]        cmd_x0,
  input  logic [XW-1:0]        cmd_x1,
  input  logic [YW-1:0]        cmd_y0,
  input  logic [YW-1:0]        cmd_y1,
  input  logic [15:0]          cmd_wx,
  input  logic [15:0]          cmd_wy,
  input  logic [31:0]          cmd_color,
  input  logic [XW:0]          eff_w,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_color
);
  import bts_pkg::*;

  localparam int AW = XW + YW;

  bk_state_t       state, state_next;
  logic [XW-1:0]   x0, x1;
  logic [YW-1:0]   y0, y1;
  logic [15:0]     wx, wy;
  logic [2:0]      rd_cnt;
  logic [2:0]      rd_cnt_next;
  logic [31:0]     t00, t01, t10, t11;
  logic [31:0]     top, bot;
  logic [AW:0]     clr_addr;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;
  logic [XW-1:0]   rx;
  logic [YW-1:0]   ry;
  logic [AW-1:0]   cmd_addr;
  logic            take;

  // Row-major address: y * width + x.
  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y,
                                            input logic [XW:0] w);
    logic [AW:0] p;
    p = y * w + x;
    return p[AW-1:0];
  endfunction

  assign clearing  = !clr_addr[AW];
  assign cmd_ready = (state == BK_IDLE) && !clearing;
  assign take      = cmd_ready && cmd_valid;
  assign cmd_addr  = addr_of(cmd_x0, cmd_y0, eff_w);

  // Clearing pass after reset, then command writes.
  always_comb begin
    ram_we    = clearing || (take && cmd_type == REQ_WRITE);
    ram_waddr = clearing ? clr_addr[AW-1:0] : cmd_addr;
    ram_wdata = clearing ? '0 : cmd_color;
    unique case (rd_cnt[1:0])
      2'd0: begin rx = x0; ry = y0; end
      2'd1: begin rx = x1; ry = y0; end
      2'd2: begin rx = x0; ry = y1; end
      default: begin rx = x1; ry = y1; end
    endcase
    ram_raddr = addr_of(rx, ry, eff_w);
  end

  bts_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next  = state;
    rd_cnt_next = rd_cnt;
    unique case (state)
      BK_IDLE: begin
        rd_cnt_next = '0;
        if (take && cmd_type != REQ_WRITE) begin
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: begin
        rd_cnt_next = rd_cnt + 3'd1;
        if (rd_cnt == 3'd4) begin
          state_next = BK_BLEND_X;
        end
      end
      BK_BLEND_X: state_next = BK_BLEND_Y;
      BK_BLEND_Y: state_next = BK_OUT;
      BK_OUT: begin
        if (out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign out_valid = (state == BK_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      rd_cnt   <= '0;
      clr_addr <= '0;
    end else begin
      state  <= state_next;
      rd_cnt <= rd_cnt_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
    if (take) begin
      x0 <= cmd_x0; x1 <= cmd_x1; y0 <= cmd_y0; y1 <= cmd_y1;
      wx <= cmd_wx; wy <= cmd_wy;
    end
    // Read data lands in the cycle after each address.
    if (state == BK_FETCH) begin
      unique case (rd_cnt)
        3'd1: t00 <= ram_rdata;
        3'd2: t01 <= ram_rdata;
        3'd3: t10 <= ram_rdata;
        3'd4: t11 <= ram_rdata;
        default: ;
      endcase
    end
    if (state == BK_BLEND_X) begin
      top <= blend4(t00, t01, wx);
      bot <= blend4(t10, t11, wx);
    end
    if (state == BK_BLEND_Y) begin
      out_color <= blend4(top, bot, wy);
    end
  end
endmodule

// ----- rtl/bilinear_texture_sampler_top.sv -----
// Bilinear RGBA8 texture sampler.
// Input beats arrive on s_axis; tdata carries pixel_x, pixel_y, sample_u,
// sample_v and the write color, tuser carries the request type. Writes give
// no output beat; point reads, bilinear and horizontal samples give one
// RGBA8 beat on m_axis. The configuration port sets image width and height.
// A front end clamps and locates coordinates over two pipeline registers;
// a back end reads up to four texels from a single-port-read store, one
// per cycle, blends in x and then in y, and holds the result for the receiver.
// A read or sample holds the back end until its result is taken: it takes the
// command, makes the four reads through the one memory read port, blends and
// presents the result. A write is stored as its command is taken.
// After reset the store is cleared one texel per cycle, 65536 texels at the
// default sizes, during which no input beat is accepted.
// Size registers reset to 256. While the receiver stalls, the
// result is held and the front end keeps one command queued and one in its
// pipeline stage, then stops accepting.
`include "bilinear_texture_sampler_top_defines.svh"
module bilinear_texture_sampler_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_x[15:0], pixel_y[31:16], sample_u[63:32], sample_v[95:64],
  // in_red[103:96], in_green[111:104], in_blue[119:112], in_alpha[127:120]
  input  logic [127:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import bts_pkg::*;

  localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CFG_W-1:0] image_width, image_height;
  logic [XW:0]      eff_w;
  logic [YW:0]      eff_h;
  logic             front_ready, clearing;
  logic             cmd_valid, cmd_ready;
  req_t             cmd_type;
  logic [XW-1:0]    cmd_x0, cmd_x1;
  logic [YW-1:0]    cmd_y0, cmd_y1;
  logic [15:0]      cmd_wx, cmd_wy;
  logic [31:0]      cmd_color;

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(256);
      image_height <= CFG_W'(256);
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_WIDTH_IDX)) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
    end
  end

  // Effective sizes, zero acts as one and large values saturate.
  always_comb begin
    if (image_width == '0) begin
      eff_w = (XW+1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = (XW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (XW+1)'(image_width);
    end
    if (image_height == '0) begin
      eff_h = (YW+1)'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = (YW+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (YW+1)'(image_height);
    end
  end

  assign s_axis_tready = front_ready && !clearing;

  bts_front #(.XW(XW), .YW(YW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid && !clearing),
    .in_ready  (front_ready),
    .req_type  (req_t'(s_axis_tuser)),
    .pixel_x   (s_axis_tdata[15:0]),
    .pixel_y   (s_axis_tdata[31:16]),
    .sample_u  (s_axis_tdata[63:32]),
    .sample_v  (s_axis_tdata[95:64]),
    .in_color  (s_axis_tdata[127:96]),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_type  (cmd_type),
    .cmd_x0    (cmd_x0),
    .cmd_x1    (cmd_x1),
    .cmd_y0    (cmd_y0),
    .cmd_y1    (cmd_y1),
    .cmd_wx    (cmd_wx),
    .cmd_wy    (cmd_wy),
    .cmd_color (cmd_color)
  );

  bts_back #(.XW(XW), .YW(YW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_type  (cmd_type),
    .cmd_x0    (cmd_x0),
    .cmd_x1    (cmd_x1),
    .cmd_y0    (cmd_y0),
    .cmd_y1    (cmd_y1),
    .cmd_wx    (cmd_wx),
    .cmd_wy    (cmd_wy),
    .cmd_color (cmd_color),
    .eff_w     (eff_w),
    .clearing  (clearing),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_color (m_axis_tdata)
  );

  // No input beat is taken while the store is being cleared.
  `BTS_ASSERT(a_no_take_clear, clk, rst, clearing |-> !s_axis_tready)
  // A stalled result keeps its color.
  `BTS_ASSERT(a_hold_out, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  // No result is shown during the clearing pass.
  `BTS_ASSERT(a_no_out_clear, clk, rst, clearing |-> !m_axis_tvalid)
  // Sizes in use are never zero once out of reset.
  `BTS_ASSERT_RST(a_size_ok, clk, rst || (eff_w != '0 && eff_h != '0))
endmodule
